/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Holds field widths, the stored job record, status and command codes and the sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

    // field widths of one job and of the result status
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned SENDER_W = 16;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned ARG_W    = 32;
    localparam int unsigned STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // one stored job
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [SENDER_W-1:0] sender;
        logic [TAG_W-1:0]    tag;
        logic [ARG_W-1:0]    arg;
    } t_entry;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PLACE,
        S_POP,
        S_DONE
    } t_state;

endpackage

/* rtl/spq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_if: command and result channels of the stable priority queue
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface spq_cmd_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [7:0]          priority_req;
    logic [15:0]         sender_id;
    logic [15:0]         conn_tag;
    logic signed [31:0]  arg_value;

    modport source (output valid, cmd, priority_req, sender_id, conn_tag, arg_value,
                    input ready);
    modport sink   (input valid, cmd, priority_req, sender_id, conn_tag, arg_value,
                    output ready);
endinterface

interface spq_res_if #(
    parameter int unsigned CNT_W = 6
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [7:0]          out_priority;
    logic [15:0]         out_sender_id;
    logic [15:0]         out_conn_tag;
    logic signed [31:0]  out_arg_value;
    logic [CNT_W-1:0]    fill_level;

    modport source (output valid, status, out_priority, out_sender_id, out_conn_tag,
                    out_arg_value, fill_level, input ready);
    modport sink   (input valid, status, out_priority, out_sender_id, out_conn_tag,
                    out_arg_value, fill_level, output ready);
endinterface

/* rtl/stable_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Sequence: a pop passes S_POP and then S_DONE; a push compares in S_CMP, moving
// one larger entry per visit, and ends in S_PLACE if it passes every entry; a
// refused push, an empty pop or a push into an empty queue go straight to S_DONE,
// which waits for the result register to be free. One item at a time: the next
// command is taken only in S_IDLE, after the result is loaded.
// Reset: synchronous active-low i_rst_n empties the queue; job memory not cleared.
// ----------------------------------------------------------------------------
// stable_priority_queue_unit: bounded job queue in a sorted ring
// A push walks back from the tail, moving strictly larger priorities one slot
// back, then places the job; a pop returns the job at the head.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_cmd_if.sink     i_cmd_if,
    spq_res_if.source   o_res_if
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // ring index helpers
    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    // job memory
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    // control registers
    t_state             r_state,   n_state;
    logic [IDX_W-1:0]   r_head,    n_head;
    logic [IDX_W-1:0]   r_tail,    n_tail;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [CNT_W-1:0]   r_passed,  n_passed;
    logic [IDX_W-1:0]   r_slot,    n_slot;
    logic [IDX_W-1:0]   r_rd_addr, n_rd_addr;
    logic               r_out_valid, n_out_valid;

    // payload registers
    t_entry             r_req,     n_req;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    t_entry             r_res,     n_res;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    t_entry             r_o_entry, n_o_entry;
    logic [CNT_W-1:0]   r_o_fill,  n_o_fill;

    // memory port controls
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_entry             w_wdata;
    logic               w_re;
    logic               w_cmd_xfer;

    assign w_cmd_xfer = i_cmd_if.valid && i_cmd_if.ready;

    // handshake and result port
    assign i_cmd_if.ready          = (r_state == S_IDLE);
    assign o_res_if.valid          = r_out_valid;
    assign o_res_if.status         = r_o_status;
    assign o_res_if.out_priority   = r_o_entry.prio;
    assign o_res_if.out_sender_id  = r_o_entry.sender;
    assign o_res_if.out_conn_tag   = r_o_entry.tag;
    assign o_res_if.out_arg_value  = $signed(r_o_entry.arg);
    assign o_res_if.fill_level     = r_o_fill;

    // memory write port and registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[n_rd_addr];
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_passed    <= '0;
            r_slot      <= '0;
            r_rd_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_passed    <= n_passed;
            r_slot      <= n_slot;
            r_rd_addr   <= n_rd_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_res_status <= n_res_status;
        r_res        <= n_res;
        r_o_status   <= n_o_status;
        r_o_entry    <= n_o_entry;
        r_o_fill     <= n_o_fill;
    end

    // sequencer: next state, memory controls and result staging
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_passed     = r_passed;
        n_slot       = r_slot;
        n_rd_addr    = r_rd_addr;
        n_out_valid  = r_out_valid;
        n_req        = r_req;
        n_res_status = r_res_status;
        n_res        = r_res;
        n_o_status   = r_o_status;
        n_o_entry    = r_o_entry;
        n_o_fill     = r_o_fill;
        w_we         = 1'b0;
        w_waddr      = r_slot;
        w_wdata      = r_req;
        w_re         = 1'b0;

        // result transfer frees the output register
        if (r_out_valid && o_res_if.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_cmd_xfer) begin
                    n_req.prio   = i_cmd_if.priority_req;
                    n_req.sender = i_cmd_if.sender_id;
                    n_req.tag    = i_cmd_if.conn_tag;
                    n_req.arg    = i_cmd_if.arg_value;
                    n_res        = '0;
                    if (i_cmd_if.cmd == CMD_PUSH) begin
                        priority if (r_count == FULL_CNT) begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end else if (r_count == '0) begin
                            // empty ring: place at the tail at once
                            w_we         = 1'b1;
                            w_waddr      = r_tail;
                            w_wdata      = n_req;
                            n_tail       = ring_inc(r_tail);
                            n_count      = r_count + 1'b1;
                            n_res_status = ST_PUSHED;
                            n_state      = S_DONE;
                        end else begin
                            n_slot    = r_tail;
                            n_passed  = '0;
                            n_rd_addr = ring_dec(r_tail);
                            w_re      = 1'b1;
                            n_state   = S_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            n_rd_addr = r_head;
                            w_re      = 1'b1;
                            n_state   = S_POP;
                        end
                    end
                end
            end

            S_CMP: begin
                w_we = 1'b1;
                if (r_rd_data.prio <= r_req.prio) begin
                    // stop behind an equal or smaller priority
                    w_waddr      = r_slot;
                    w_wdata      = r_req;
                    n_tail       = ring_inc(r_tail);
                    n_count      = r_count + 1'b1;
                    n_res_status = ST_PUSHED;
                    n_state      = S_DONE;
                end else begin
                    // move the larger entry one slot back
                    w_waddr  = r_slot;
                    w_wdata  = r_rd_data;
                    n_slot   = r_rd_addr;
                    n_passed = r_passed + 1'b1;
                    if (n_passed < r_count) begin
                        n_rd_addr = ring_dec(r_rd_addr);
                        w_re      = 1'b1;
                    end else begin
                        n_state = S_PLACE;
                    end
                end
            end

            S_PLACE: begin
                w_we         = 1'b1;
                w_waddr      = r_slot;
                w_wdata      = r_req;
                n_tail       = ring_inc(r_tail);
                n_count      = r_count + 1'b1;
                n_res_status = ST_PUSHED;
                n_state      = S_DONE;
            end

            S_POP: begin
                n_res        = r_rd_data;
                n_res_status = ST_POPPED;
                n_head       = ring_inc(r_head);
                n_count      = r_count - 1'b1;
                n_state      = S_DONE;
            end

            S_DONE: begin
                // load the output register once it is free
                if (!r_out_valid || o_res_if.ready) begin
                    n_o_status  = r_res_status;
                    n_o_entry   = r_res;
                    n_o_fill    = r_count;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // count never exceeds the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond depth");

    // the insert walk never passes more entries than are held
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_passed < r_count))
        else $error("insert walk past held entries");

    // a refused push reports a full queue
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_if.valid && o_res_if.status == ST_FULL) |-> (o_res_if.fill_level == FULL_CNT))
        else $error("full status with partial fill");

    // an empty pop reports zero fill and zero priority
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_if.valid && o_res_if.status == ST_EMPTY)
        |-> (o_res_if.fill_level == '0 && o_res_if.out_priority == '0))
        else $error("empty status with nonzero fields");

    // a popped job leaves the count one lower at the next step
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not decrement count");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stable priority queue unit
// A short scripted sequence covers the empty and absent-argument cases, the
// field extremes and the ordering of equal priorities. Random phases follow
// that fill, drain or mix the queue, full refusals among them. A sorted job
// list gives each expected result that is not typed in, and the results are
// compared field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = 32;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SCRIPT_ROWS    = 25;
    localparam logic [31:0] ARG_ABSENT = 32'hFFFF_FFFE;

    // idle modes of a channel
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_HEAVY = 2;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase;

    // one result as seen on the result channel
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  prio;
        logic [15:0] sender;
        logic [15:0] tag;
        logic [31:0] arg;
        logic [5:0]  fill;
    } t_result;

    // one scripted command, with a typed-in result where it is obvious
    typedef struct {
        logic        cmd;
        logic [7:0]  prio;
        logic [15:0] sender;
        logic [15:0] tag;
        logic [31:0] arg;
        bit          typed;
        logic [1:0]  want_status;
        logic [5:0]  want_fill;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    spq_cmd_if              cmd_ch ();
    spq_res_if #(.CNT_W(6)) res_ch ();

    stable_priority_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_if (cmd_ch),
        .o_res_if (res_ch)
    );

    t_entry  held_jobs[$];
    t_result awaited_results[$];
    int      mismatch_count = 0;
    int      result_index   = 0;
    int      stalled_cycles = 0;
    int      send_idle      = IDLE_NONE;
    int      recv_idle      = IDLE_NONE;
    bit      hold_request   = 1'b0;

    // scripted opening sequence
    t_script_row script_rows [SCRIPT_ROWS] = '{
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, ST_EMPTY,  6'd0},
        '{CMD_PUSH, 8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, ST_PUSHED, 6'd1},
        '{CMD_PUSH, 8'd255, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_PUSHED, 6'd2},
        '{CMD_PUSH, 8'd255, 16'h1234, 16'h0001, ARG_ABSENT,    1'b1, ST_PUSHED, 6'd3},
        '{CMD_PUSH, 8'd128, 16'hA5A5, 16'h5A5A, 32'h1234_5678, 1'b1, ST_PUSHED, 6'd4},
        '{CMD_PUSH, 8'd5,   16'h0001, 16'h8000, 32'h8000_0000, 1'b1, ST_PUSHED, 6'd5},
        '{CMD_PUSH, 8'd5,   16'h0002, 16'h7FFF, 32'h7FFF_FFFF, 1'b1, ST_PUSHED, 6'd6},
        '{CMD_PUSH, 8'd5,   16'h0003, 16'h0003, ARG_ABSENT,    1'b1, ST_PUSHED, 6'd7},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd6},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd5},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd4},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd3},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd2},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd1},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd0},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, ST_EMPTY,  6'd0},
        '{CMD_PUSH, 8'd10,  16'h0010, 16'h0100, 32'h0000_0001, 1'b1, ST_PUSHED, 6'd1},
        '{CMD_PUSH, 8'd9,   16'h0011, 16'h0101, 32'hFFFF_FFFF, 1'b1, ST_PUSHED, 6'd2},
        '{CMD_PUSH, 8'd10,  16'h0012, 16'h0102, 32'h0000_0002, 1'b1, ST_PUSHED, 6'd3},
        '{CMD_PUSH, 8'd8,   16'h0013, 16'h0103, 32'h0000_0003, 1'b1, ST_PUSHED, 6'd4},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd3},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd2},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd1},
        '{CMD_PUSH, 8'd0,   16'hFFFF, 16'h0000, 32'h0000_0000, 1'b1, ST_PUSHED, 6'd2},
        '{CMD_POP,  8'd0,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_POPPED, 6'd1}
    };

    // clock and reset
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // expected queue behavior: jobs kept in serving order
    function automatic t_result serve_job(input logic cmd, input t_entry job);
        t_result outcome;
        t_entry  first;
        int      slot;
        outcome = '0;
        if (cmd == CMD_PUSH) begin
            if (held_jobs.size() >= QUEUE_DEPTH) begin
                outcome.status = ST_FULL;
            end else begin
                // stable insert: behind every job of smaller or equal priority
                slot = held_jobs.size();
                while (slot > 0 && held_jobs[slot-1].prio > job.prio)
                    slot--;
                held_jobs.insert(slot, job);
                outcome.status = ST_PUSHED;
            end
        end else if (held_jobs.size() == 0) begin
            outcome.status = ST_EMPTY;
        end else begin
            first          = held_jobs.pop_front();
            outcome.status = ST_POPPED;
            outcome.prio   = first.prio;
            outcome.sender = first.sender;
            outcome.tag    = first.tag;
            outcome.arg    = first.arg;
        end
        outcome.fill = 6'(held_jobs.size());
        return outcome;
    endfunction

    // gap length: mostly none or short, a few long
    function automatic int pick_gap(input int mode);
        int roll;
        if (mode == IDLE_NONE)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < ((mode == IDLE_LIGHT) ? 75 : 40))
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random job: ties, extremes and full-range priorities
    task automatic make_job(input int push_pct, output logic cmd, output t_entry job);
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        case ($urandom_range(0, 3))
            0:       job.prio = 8'($urandom_range(0, 3));
            1:       job.prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: job.prio = 8'($urandom);
        endcase
        job.sender = 16'($urandom);
        job.tag    = 16'($urandom);
        job.arg    = ($urandom_range(0, 15) == 0) ? ARG_ABSENT : 32'($urandom);
    endtask

    // offer one command and wait for its transfer, then record the expectation
    task automatic offer_job(input logic cmd, input t_entry job, input bit typed,
                             input t_result typed_res);
        t_result predicted;
        int      gap;
        gap = pick_gap(send_idle);
        if (gap > 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.cmd          = cmd;
        cmd_ch.priority_req = job.prio;
        cmd_ch.sender_id    = job.sender;
        cmd_ch.conn_tag     = job.tag;
        cmd_ch.arg_value    = job.arg;
        cmd_ch.valid        = 1'b1;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        predicted = serve_job(cmd, job);
        awaited_results.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // stimulus: scripted rows, then random phases, then drain
    initial begin
        t_entry  job;
        t_result typed_res;
        logic    cmd;
        int      items_sent;
        int      phase_len;
        int      push_pct;
        t_phase  phase;
        cmd_ch.valid        = 1'b0;
        cmd_ch.cmd          = CMD_PUSH;
        cmd_ch.priority_req = '0;
        cmd_ch.sender_id    = '0;
        cmd_ch.conn_tag     = '0;
        cmd_ch.arg_value    = '0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        foreach (script_rows[i]) begin
            job.prio          = script_rows[i].prio;
            job.sender        = script_rows[i].sender;
            job.tag           = script_rows[i].tag;
            job.arg           = script_rows[i].arg;
            typed_res         = '0;
            typed_res.status  = script_rows[i].want_status;
            typed_res.fill    = script_rows[i].want_fill;
            offer_job(script_rows[i].cmd, job, script_rows[i].typed, typed_res);
        end

        // first phase fills the queue against a long receiver hold-off
        hold_request = 1'b1;
        phase        = PH_FILL;
        send_idle    = IDLE_NONE;
        items_sent   = 0;
        typed_res    = '0;
        while (items_sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 120);
            case (phase)
                PH_FILL:  push_pct = 85;
                PH_DRAIN: push_pct = 15;
                default:  push_pct = 50;
            endcase
            repeat (phase_len) begin
                make_job(push_pct, cmd, job);
                offer_job(cmd, job, 1'b0, typed_res);
                items_sent++;
            end
            phase     = t_phase'($urandom_range(0, 2));
            send_idle = $urandom_range(IDLE_NONE, IDLE_HEAVY);
            recv_idle = $urandom_range(IDLE_NONE, IDLE_HEAVY);
        end
        cmd_ch.valid = 1'b0;

        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("stable_priority_queue_unit test passed");
        else
            $display("stable_priority_queue_unit test failed");
        $finish;
    end

    // result receiver: random stalls and one long hold-off
    initial begin
        int gap;
        bit hold_done;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done    = 1'b1;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = pick_gap(recv_idle);
            if (gap > 0) begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            @(negedge i_clk);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_index, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no command pending");
            end else begin
                want = awaited_results.pop_front();
                check_field("status",        32'(res_ch.status),        32'(want.status));
                check_field("out_priority",  32'(res_ch.out_priority),  32'(want.prio));
                check_field("out_sender_id", 32'(res_ch.out_sender_id), 32'(want.sender));
                check_field("out_conn_tag",  32'(res_ch.out_conn_tag),  32'(want.tag));
                check_field("out_arg_value", res_ch.out_arg_value,      want.arg);
                check_field("fill_level",    32'(res_ch.fill_level),    32'(want.fill));
            end
            result_index++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("stable_priority_queue_unit test failed");
            $finish;
        end
    end

endmodule

/* sim.f */
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/stable_priority_queue_unit.sv
sim/testbench.sv
